### rtl/quadratic_root_solver_defines.svh
// Assertion macros for the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define QRS_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");

// Check that a condition holds in the cycle after its trigger.
`define QRS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

`endif

### rtl/qrs_pkg.sv
// Shared types for the quadratic root solver.
package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_ERROR    = 2'd3
    } t_root_kind;

endpackage

### rtl/qrs_coeff_if.sv
// Coefficient channel: valid/ready with a, b, c.
interface qrs_coeff_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] coeff_a;
    logic signed [DATA_WIDTH-1:0] coeff_b;
    logic signed [DATA_WIDTH-1:0] coeff_c;

    modport source (output valid, output coeff_a, output coeff_b, output coeff_c,
                    input ready);
    modport sink   (input valid, input coeff_a, input coeff_b, input coeff_c,
                    output ready);
endinterface

### rtl/qrs_root_if.sv
// Root channel: valid/ready with kind, two values and overflow flag.
interface qrs_root_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    qrs_pkg::t_root_kind          root_kind;
    logic signed [DATA_WIDTH-1:0] first_value;
    logic signed [DATA_WIDTH-1:0] second_value;
    logic                         overflow;

    modport source (output valid, output root_kind, output first_value,
                    output second_value, output overflow, input ready);
    modport sink   (input valid, input root_kind, input first_value,
                    input second_value, input overflow, output ready);
endinterface

### rtl/quadratic_root_solver.sv
// Quadratic root solver top level: discriminant, square root, two quotients.
//
//  channel    dir   modport  payload
//  i_coeff    in    sink     coeff_a, coeff_b, coeff_c  (signed Q16.16)
//  o_root     out   source   root_kind, first_value, second_value, overflow
//
//  One word enters per cycle while i_coeff.ready is high; the square root and divider
//  are bit-per-stage pipelines.
//  All stages advance together; i_coeff.ready is low only while the output
//  register holds a word that o_root.ready does not take, and then every stage holds.
//  i_rst_n is synchronous and clears only the valid bits.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qrs_coeff_if.sink    i_coeff,
    qrs_root_if.source   o_root
);
    import qrs_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int PROD_W = 2 * W;          // b*b and a*c
    localparam int DISC_W = 2 * W + 1;      // |D|
    localparam int ROOT_W = W + 1;          // sqrt(|D|)
    localparam int MAG_W  = W + 2;          // |-b +/- s|
    localparam int QUOT_W = MAG_W + FRAC_BITS;
    localparam int DIV_W  = W + 1;          // 2|a|
    localparam int SSIDE_W = 2 * W + 5;
    localparam int DSIDE_W = 4;
    localparam logic [QUOT_W-1:0] LIM_POS = (QUOT_W'(1) << (W - 1)) - QUOT_W'(1);
    localparam logic [QUOT_W-1:0] LIM_NEG = QUOT_W'(1) << (W - 1);

    // global advance: the whole pipe moves unless the output word is stuck
    logic w_en;
    logic r_out_v;
    assign w_en          = !r_out_v || o_root.ready;
    assign i_coeff.ready = w_en;

    // ---------------- stage 0: register magnitudes and signs ----------------
    logic         r0_v;
    logic [W-1:0] r0_amag, r0_bmag, r0_cmag;
    logic         r0_aneg, r0_bneg, r0_cneg;
    logic [W-1:0] w_amag, w_bmag, w_cmag;

    assign w_amag = i_coeff.coeff_a[W-1] ? (~i_coeff.coeff_a + 1'b1) : i_coeff.coeff_a;
    assign w_bmag = i_coeff.coeff_b[W-1] ? (~i_coeff.coeff_b + 1'b1) : i_coeff.coeff_b;
    assign w_cmag = i_coeff.coeff_c[W-1] ? (~i_coeff.coeff_c + 1'b1) : i_coeff.coeff_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_coeff.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_amag <= w_amag;
            r0_bmag <= w_bmag;
            r0_cmag <= w_cmag;
            r0_aneg <= i_coeff.coeff_a[W-1];
            r0_bneg <= i_coeff.coeff_b[W-1];
            r0_cneg <= i_coeff.coeff_c[W-1];
        end
    end

    // ---------------- stage 1: b*b and a*c ----------------
    logic              r1_v;
    logic [PROD_W-1:0] r1_b2, r1_ac;
    logic [W-1:0]      r1_amag, r1_bmag;
    logic              r1_aneg, r1_bneg, r1_dsub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_b2   <= PROD_W'(r0_bmag) * PROD_W'(r0_bmag);
            r1_ac   <= PROD_W'(r0_amag) * PROD_W'(r0_cmag);
            r1_amag <= r0_amag;
            r1_bmag <= r0_bmag;
            r1_aneg <= r0_aneg;
            r1_bneg <= r0_bneg;
            r1_dsub <= (r0_aneg == r0_cneg);   // 4ac has the sign of b*b
        end
    end

    // ---------------- stage 2: discriminant magnitude and sign ----------------
    logic                r2_v;
    logic [DISC_W-1:0]   r2_dmag;
    logic                r2_dneg;
    logic [W-1:0]        r2_amag, r2_bmag;
    logic                r2_aneg, r2_bneg;
    logic [PROD_W+1:0]   w_b2x, w_ac4;
    logic [PROD_W+1:0]   w_dmag;
    logic                w_dneg;

    assign w_b2x = (PROD_W+2)'(r1_b2);
    assign w_ac4 = {r1_ac, 2'b00};

    always_comb begin
        w_dneg = 1'b0;
        if (!r1_dsub) begin
            w_dmag = w_b2x + w_ac4;
        end else if (w_b2x >= w_ac4) begin
            w_dmag = w_b2x - w_ac4;
        end else begin
            w_dmag = w_ac4 - w_b2x;
            w_dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dmag <= w_dmag[DISC_W-1:0];
            r2_dneg <= w_dneg;
            r2_amag <= r1_amag;
            r2_bmag <= r1_bmag;
            r2_aneg <= r1_aneg;
            r2_bneg <= r1_bneg;
        end
    end

    // ---------------- square root of |D| ----------------
    logic               w_sq_v;
    logic [ROOT_W-1:0]  w_sq_root;
    logic [SSIDE_W-1:0] w_sq_side_in, w_sq_side;

    assign w_sq_side_in = {(r2_dmag == '0), r2_dneg, (r2_amag == '0), r2_aneg, r2_bneg,
                           r2_bmag, r2_amag};

    qrs_sqrt_pipe #(
        .IN_W   (2 * ROOT_W),
        .SIDE_W (SSIDE_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r2_v),
        .i_radicand ({1'b0, r2_dmag}),
        .i_side     (w_sq_side_in),
        .o_valid    (w_sq_v),
        .o_root     (w_sq_root),
        .o_side     (w_sq_side)
    );

    // ---------------- stage 3: kind, numerators, divisor ----------------
    logic                    w_dzero, w_dneg3, w_azero, w_aneg3, w_bneg3;
    logic [W-1:0]            w_bmag3, w_amag3;
    logic signed [MAG_W:0]   w_nb, w_s, w_num1, w_num2;
    t_root_kind              w_kind;

    assign {w_dzero, w_dneg3, w_azero, w_aneg3, w_bneg3, w_bmag3, w_amag3} = w_sq_side;
    assign w_nb = w_bneg3 ? (MAG_W+1)'(w_bmag3) : -(MAG_W+1)'(w_bmag3);
    assign w_s  = (MAG_W+1)'(w_sq_root);

    always_comb begin
        if (w_azero) begin
            w_kind = KIND_ERROR;
        end else if (w_dzero) begin
            w_kind = KIND_DOUBLE;
        end else if (!w_dneg3) begin
            w_kind = KIND_TWO_REAL;
        end else begin
            w_kind = KIND_COMPLEX;
        end
    end

    always_comb begin
        case (w_kind)
            KIND_TWO_REAL: begin
                w_num1 = w_nb + w_s;
                w_num2 = w_nb - w_s;
            end
            KIND_COMPLEX: begin
                w_num1 = w_nb;
                w_num2 = w_s;
            end
            default: begin
                w_num1 = w_nb;
                w_num2 = w_nb;
            end
        endcase
    end

    logic              r3_v;
    t_root_kind        r3_kind;
    logic [MAG_W-1:0]  r3_n1mag, r3_n2mag;
    logic              r3_q1neg, r3_q2neg;
    logic [DIV_W-1:0]  r3_dv;
    logic [MAG_W:0]    w_n1abs, w_n2abs;

    assign w_n1abs = w_num1[MAG_W] ? (~w_num1 + 1'b1) : w_num1;
    assign w_n2abs = w_num2[MAG_W] ? (~w_num2 + 1'b1) : w_num2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind  <= w_kind;
            r3_n1mag <= w_n1abs[MAG_W-1:0];
            r3_n2mag <= w_n2abs[MAG_W-1:0];
            r3_q1neg <= w_num1[MAG_W] ^ w_aneg3;
            r3_q2neg <= w_num2[MAG_W] ^ w_aneg3;
            r3_dv    <= {w_amag3, 1'b0};
        end
    end

    // ---------------- (num << FRAC_BITS) / 2|a| on two lanes ----------------
    logic               w_dq_v;
    logic [QUOT_W-1:0]  w_q1, w_q2;
    logic [DSIDE_W-1:0] w_dq_side;

    qrs_div_pipe #(
        .NUM_W  (QUOT_W),
        .DIV_W  (DIV_W),
        .SIDE_W (DSIDE_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r3_v),
        .i_num1    (QUOT_W'(r3_n1mag) << FRAC_BITS),
        .i_num2    (QUOT_W'(r3_n2mag) << FRAC_BITS),
        .i_divisor (r3_dv),
        .i_side    ({r3_kind, r3_q1neg, r3_q2neg}),
        .o_valid   (w_dq_v),
        .o_quot1   (w_q1),
        .o_quot2   (w_q2),
        .o_side    (w_dq_side)
    );

    // ---------------- output stage: saturate, sign, hold ----------------
    t_root_kind        w_okind;
    logic              w_oq1neg, w_oq2neg;
    logic              w_ovf1, w_ovf2;
    logic [QUOT_W-1:0] w_m1, w_m2;
    logic [W-1:0]      w_v1, w_v2;

    assign w_okind  = t_root_kind'(w_dq_side[3:2]);
    assign w_oq1neg = w_dq_side[1];
    assign w_oq2neg = w_dq_side[0];
    assign w_ovf1   = w_oq1neg ? (w_q1 > LIM_NEG) : (w_q1 > LIM_POS);
    assign w_ovf2   = w_oq2neg ? (w_q2 > LIM_NEG) : (w_q2 > LIM_POS);
    assign w_m1     = w_ovf1 ? (w_oq1neg ? LIM_NEG : LIM_POS) : w_q1;
    assign w_m2     = w_ovf2 ? (w_oq2neg ? LIM_NEG : LIM_POS) : w_q2;
    assign w_v1     = w_oq1neg ? (~w_m1[W-1:0] + 1'b1) : w_m1[W-1:0];
    assign w_v2     = w_oq2neg ? (~w_m2[W-1:0] + 1'b1) : w_m2[W-1:0];

    t_root_kind   r_out_kind;
    logic [W-1:0] r_out_v1, r_out_v2;
    logic         r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_kind <= w_okind;
            if (w_okind == KIND_ERROR) begin
                // a is zero: drop the quotients
                r_out_v1  <= '0;
                r_out_v2  <= '0;
                r_out_ovf <= 1'b0;
            end else begin
                r_out_v1  <= w_v1;
                r_out_v2  <= w_v2;
                r_out_ovf <= w_ovf1 | w_ovf2;
            end
        end
    end

    assign o_root.valid        = r_out_v;
    assign o_root.root_kind    = r_out_kind;
    assign o_root.first_value  = r_out_v1;
    assign o_root.second_value = r_out_v2;
    assign o_root.overflow     = r_out_ovf;

    // ---------------- checks ----------------
    `QRS_ASSERT_SAME(a_error_is_zero, i_clk, i_rst_n, o_root.valid && o_root.root_kind == KIND_ERROR, o_root.first_value == '0 && o_root.second_value == '0 && !o_root.overflow)
    `QRS_ASSERT_SAME(a_double_equal, i_clk, i_rst_n, o_root.valid && o_root.root_kind == KIND_DOUBLE, o_root.first_value == o_root.second_value)
    `QRS_ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, !i_coeff.ready, o_root.valid)
    `QRS_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_coeff.valid && i_coeff.ready, r0_v)

endmodule

### rtl/qrs_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt_pipe #(
    parameter int IN_W   = 66,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_radicand,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic              r_v    [OUT_W];
    logic [REM_W-1:0]  r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_res  [OUT_W];
    logic [IN_W-1:0]   r_rad  [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic              w_v_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [OUT_W-1:0]  w_res_in;
        logic [IN_W-1:0]   w_rad_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [REM_W+1:0]  w_cur;
        logic [REM_W+1:0]  w_trial;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = '0;
            assign w_res_in  = '0;
            assign w_rad_in  = i_radicand;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_res_in  = r_res[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_side_in = r_side[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_cur   = {w_rem_in, w_rad_in[IN_W-1 -: 2]};
        assign w_trial = (REM_W+2)'({w_res_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem[k] <= REM_W'(w_cur - w_trial);
                    r_res[k] <= {w_res_in[OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= REM_W'(w_cur);
                    r_res[k] <= {w_res_in[OUT_W-2:0], 1'b0};
                end
                r_rad[k]  <= w_rad_in << 2;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_res[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];

endmodule

### rtl/qrs_div_pipe.sv
// Two-lane pipelined restoring divider with a shared divisor, one bit per stage.
module qrs_div_pipe #(
    parameter int NUM_W  = 50,
    parameter int DIV_W  = 33,
    parameter int SIDE_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num1,
    input  logic [NUM_W-1:0]  i_num2,
    input  logic [DIV_W-1:0]  i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot1,
    output logic [NUM_W-1:0]  o_quot2,
    output logic [SIDE_W-1:0] o_side
);
    // r_nq holds the dividend bits still to consume on top and quotient bits below
    logic              r_v    [NUM_W];
    logic [DIV_W-1:0]  r_rem1 [NUM_W];
    logic [DIV_W-1:0]  r_rem2 [NUM_W];
    logic [NUM_W-1:0]  r_nq1  [NUM_W];
    logic [NUM_W-1:0]  r_nq2  [NUM_W];
    logic [DIV_W-1:0]  r_dv   [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              w_v_in;
        logic [DIV_W-1:0]  w_rem1_in;
        logic [DIV_W-1:0]  w_rem2_in;
        logic [NUM_W-1:0]  w_nq1_in;
        logic [NUM_W-1:0]  w_nq2_in;
        logic [DIV_W-1:0]  w_dv_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [DIV_W:0]    w_cur1;
        logic [DIV_W:0]    w_cur2;
        logic [DIV_W:0]    w_dvx;
        logic              w_bit1;
        logic              w_bit2;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem1_in = '0;
            assign w_rem2_in = '0;
            assign w_nq1_in  = i_num1;
            assign w_nq2_in  = i_num2;
            assign w_dv_in   = i_divisor;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem1_in = r_rem1[k-1];
            assign w_rem2_in = r_rem2[k-1];
            assign w_nq1_in  = r_nq1[k-1];
            assign w_nq2_in  = r_nq2[k-1];
            assign w_dv_in   = r_dv[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign w_cur1 = {w_rem1_in, w_nq1_in[NUM_W-1]};
        assign w_cur2 = {w_rem2_in, w_nq2_in[NUM_W-1]};
        assign w_dvx  = {1'b0, w_dv_in};
        assign w_bit1 = (w_cur1 >= w_dvx);
        assign w_bit2 = (w_cur2 >= w_dvx);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem1[k] <= w_bit1 ? DIV_W'(w_cur1 - w_dvx) : DIV_W'(w_cur1);
                r_rem2[k] <= w_bit2 ? DIV_W'(w_cur2 - w_dvx) : DIV_W'(w_cur2);
                r_nq1[k]  <= {w_nq1_in[NUM_W-2:0], w_bit1};
                r_nq2[k]  <= {w_nq2_in[NUM_W-2:0], w_bit2};
                r_dv[k]   <= w_dv_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot1 = r_nq1[NUM_W-1];
    assign o_quot2 = r_nq2[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule
